### rtl/core/integer_to_roman_encoder_macros.svh
// ---------------------------------------------------------------------------
// Integer to Roman encoder assertion macros
// Shared concurrent assertion forms for the encoder RTL.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_ENCODER_MACROS_SVH
`define INTEGER_TO_ROMAN_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2R_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2r assertion failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define I2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2r assertion failed (next cycle)");

`endif

### rtl/core/i2r_pkg.sv
// ---------------------------------------------------------------------------
// Integer to Roman encoder package
// Widths, numeral term tables, controller state and command types.
// ---------------------------------------------------------------------------
package i2r_pkg;

	localparam int VALUE_W = 12;
	localparam int CHAR_W  = 7;
	localparam int N_TERMS = 13;
	localparam int TERM_W  = $clog2(N_TERMS);

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [TERM_W-1:0]  term_idx_t;

	localparam char_t CH_NONE = 7'h00;
	localparam char_t CH_I    = 7'h49;
	localparam char_t CH_V    = 7'h56;
	localparam char_t CH_X    = 7'h58;
	localparam char_t CH_L    = 7'h4C;
	localparam char_t CH_C    = 7'h43;
	localparam char_t CH_D    = 7'h44;
	localparam char_t CH_M    = 7'h4D;

	// Terms in descending order; second letter is CH_NONE for single letters.
	localparam value_t TERM_AMOUNT [N_TERMS] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};
	localparam char_t TERM_FIRST [N_TERMS] = '{
		CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
	};
	localparam char_t TERM_SECOND [N_TERMS] = '{
		CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L,
		CH_NONE, CH_X, CH_NONE, CH_V, CH_NONE
	};

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} i2r_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} i2r_cmd_t;

	typedef struct packed {
		logic last;
	} i2r_stat_t;

endpackage

### rtl/core/i2r_if.sv
// ---------------------------------------------------------------------------
// Integer to Roman encoder channels
// Valid/ready channels for the input value and the output characters.
// ---------------------------------------------------------------------------
interface i2r_value_if import i2r_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface i2r_char_if import i2r_pkg::*; ();
	logic  valid;
	logic  ready;
	char_t char_code;
	logic  is_last;
	logic  is_empty;

	modport source (output valid, output char_code, output is_last, output is_empty,
		input ready);
	modport sink (input valid, input char_code, input is_last, input is_empty,
		output ready);
endinterface

### rtl/core/integer_to_roman_encoder.sv
// ---------------------------------------------------------------------------
// Integer to Roman numeral encoder
// Converts a 12-bit unsigned value into a stream of ASCII numeral letters.
// ---------------------------------------------------------------------------
// Each item on the number channel is a value from 0 to 4095; the numeral
// channel returns its Roman numeral one ASCII letter per item, in reading
// order, with is_last set on the final letter. Zero returns a single item
// with char_code 0 and both is_last and is_empty set. Values from 4000 up
// start with four M letters. The letters are registered into the output
// register one per cycle through the subtract-and-select unit while the
// numeral channel is not stalled, and the next value can be accepted once
// the last letter is registered, while it still waits in the output
// register. A numeral runs 1 to 15 letters. Back-pressure on the numeral
// channel holds the letter sequence.
// ---------------------------------------------------------------------------
module integer_to_roman_encoder import i2r_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	i2r_value_if.sink  number,
	i2r_char_if.source numeral
);

	i2r_cmd_t  cmd;
	i2r_stat_t stat;

	// Controller: accept one value, then step one letter per free output slot.
	i2r_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number.valid),
		.in_ready  (number.ready),
		.out_valid (numeral.valid),
		.out_ready (numeral.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: hold the remainder, pick the largest fitting term, drive letters.
	i2r_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (number.value),
		.stat      (stat),
		.char_code (numeral.char_code),
		.is_last   (numeral.is_last),
		.is_empty  (numeral.is_empty)
	);

endmodule

### rtl/core/i2r_dpath.sv
// ---------------------------------------------------------------------------
// Integer to Roman encoder datapath
// Remainder register, pending second letter and output character register.
// ---------------------------------------------------------------------------
module i2r_dpath import i2r_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  i2r_cmd_t  cmd,
	input  value_t    value,
	output i2r_stat_t stat,
	output char_t     char_code,
	output logic      is_last,
	output logic      is_empty
);

`include "integer_to_roman_encoder_macros.svh"

	value_t    rest_q;
	logic      pend_q;
	char_t     pend_char_q;
	char_t     char_q;
	logic      last_q;
	logic      empty_q;

	term_idx_t sel;
	value_t    rest_next;
	char_t     emit_char;
	logic      emit_last;
	logic      emit_empty;
	logic      set_pend;

	// Largest term that fits the remainder; the compares are independent.
	always_comb begin
		sel = term_idx_t'(N_TERMS - 1);
		for (int k = N_TERMS - 1; k >= 0; k--) begin
			if (rest_q >= TERM_AMOUNT[k]) begin
				sel = term_idx_t'(k);
			end
		end
	end

	always_comb begin
		rest_next  = rest_q;
		emit_char  = CH_NONE;
		emit_last  = 1'b0;
		emit_empty = 1'b0;
		set_pend   = 1'b0;
		priority if (pend_q) begin
			emit_char = pend_char_q;
			emit_last = (rest_q == '0);
		end else if (rest_q == '0) begin
			emit_last  = 1'b1;
			emit_empty = 1'b1;
		end else begin
			rest_next = rest_q - TERM_AMOUNT[sel];
			emit_char = TERM_FIRST[sel];
			set_pend  = (TERM_SECOND[sel] != CH_NONE);
			emit_last = !set_pend && (rest_next == '0);
		end
	end

	assign stat.last = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd.load) begin
			pend_q <= 1'b0;
		end else if (cmd.step) begin
			pend_q <= set_pend;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= value;
		end else if (cmd.step) begin
			rest_q      <= rest_next;
			pend_char_q <= TERM_SECOND[sel];
			char_q      <= emit_char;
			last_q      <= emit_last;
			empty_q     <= emit_empty;
		end
	end

	assign char_code = char_q;
	assign is_last   = last_q;
	assign is_empty  = empty_q;

	`I2R_ASSERT_NEXT(a_pend_drains, clk, arst_n, cmd.step && pend_q, !pend_q)
	`I2R_ASSERT_NOW(a_empty_is_last, clk, arst_n, cmd.step && emit_empty, emit_last)
	`I2R_ASSERT_NOW(a_pend_not_last, clk, arst_n, cmd.step && set_pend, !emit_last)

endmodule

### rtl/core/i2r_ctrl.sv
// ---------------------------------------------------------------------------
// Integer to Roman encoder controller
// Sequences load and character steps, owns the handshake control bits.
// ---------------------------------------------------------------------------
module i2r_ctrl import i2r_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  i2r_stat_t stat,
	output i2r_cmd_t  cmd
);

`include "integer_to_roman_encoder_macros.svh"

	i2r_state_t state_q;
	i2r_state_t state_next;
	logic       out_vld_q;
	logic       advance;

	// Output register is free when empty or being drained this cycle.
	assign advance  = !out_vld_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign cmd.load = (state_q == ST_IDLE) && in_valid;
	assign cmd.step = (state_q == ST_RUN) && advance;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (advance && stat.last) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.step) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

	`I2R_ASSERT_NEXT(a_last_ends_run, clk, arst_n, cmd.step && stat.last, state_q == ST_IDLE)
	`I2R_ASSERT_NOW(a_step_needs_room, clk, arst_n, cmd.step, !out_vld_q || out_ready)
	`I2R_ASSERT_NEXT(a_step_fills_out, clk, arst_n, cmd.step, out_vld_q)
	`I2R_ASSERT_NOW(a_load_only_idle, clk, arst_n, cmd.load, !cmd.step)

endmodule
